[sv/particle_update_step_defines.svh]
// particle_update_step_defines.svh: assertion macros for the particle update block.
// Needs a clk and an rst signal in the scope of use.
`ifndef PARTICLE_UPDATE_STEP_DEFINES_SVH
`define PARTICLE_UPDATE_STEP_DEFINES_SVH

// same-cycle implication, off during reset
`define PUS_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PUS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

[sv/pus_pkg.sv]
// pus_pkg: field widths, packing offsets and helpers for the particle update block.
// No dependencies.
`timescale 1ns / 1ps
package pus_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int AGE_W  = 24;
  localparam int POS_W  = 32;
  localparam int OPA_W  = 17;
  localparam int DT_W   = 16;
  localparam int DRAG_W = 16;
  localparam int CFG_W  = 32;
  localparam int IN_W   = 280;
  localparam int OUT_W  = 240;

  // register indexes
  localparam logic REG_GRAVITY = 1'b0;
  localparam logic REG_DRAG    = 1'b1;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic [POS_W-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = x[POS_W-1:0];
    end
  endfunction
endpackage

[sv/particle_update_step.sv]
// particle_update_step: pipelined fixed-point Euler update of one particle record.
// Depends on pus_pkg and particle_update_step_defines.svh.
`timescale 1ns / 1ps
// Usage:
//  - s_axis carries one particle record plus its time step per request; m_axis
//    returns the updated record. Both use tvalid/tready; a request moves when both
//    are high.
//  - cfg_we/cfg_index/cfg_data write gravity_accel (index 0) and drag_coeff
//    (index 1). Write only while the pipe is empty. Both reset to zero.
//  - One request enters per cycle; throughput is one record per clock while
//    m_axis is not held off.
//  - Pipe depth is set by the life-ratio divider: a restoring divider with one
//    quotient bit per stage. The velocity and position math rides in the first
//    five stages alongside it; the opacity square and scale take the last two.
//  - Each stage holds its data when the stage after it is full and stalled, so
//    empty stages keep filling while m_axis is held off; tready on s_axis drops
//    only when every stage is full and the output is not taken.
//  - rst (synchronous) empties the pipe and clears both registers.
//  - Dead or expiring particles keep position and velocity and report zero
//    opacity; expired ones report the advanced age.
module particle_update_step
  import pus_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] in_active, [24:1] in_age, [48:25] in_max_age, [80:49] in_pos_x,
  // [112:81] in_pos_y, [144:113] in_pos_z, [176:145] in_vel_x, [208:177] in_vel_y,
  // [240:209] in_vel_z, [257:241] base_opacity, [273:258] time_step, rest zero
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [0] out_active, [24:1] out_age, [56:25] out_pos_x, [88:57] out_pos_y,
  // [120:89] out_pos_z, [152:121] out_vel_x, [184:153] out_vel_y,
  // [216:185] out_vel_z, [233:217] out_opacity, rest zero
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
`include "particle_update_step_defines.svh"

  localparam int NST = FRAC_BITS + 3;
  localparam int PMW = POS_W + DT_W + 1;

  typedef struct packed {
    logic                       alive;
    logic [AGE_W-1:0]           age;
    logic [AGE_W-1:0]           max_age;
    logic [2:0][POS_W-1:0]      pos;
    logic [2:0][POS_W-1:0]      vel;
    logic [OPA_W-1:0]           base;
    logic [DT_W-1:0]            dt;
    logic signed [POS_W+DT_W:0] gp;    // gravity * dt
    logic [DRAG_W+DT_W-1:0]     dp;    // drag * dt
    logic [FRAC_BITS:0]         k;     // drag factor
    logic [2:0][PMW-1:0]        pm;    // velocity * dt
    logic [AGE_W-1:0]           rem;
    logic [FRAC_BITS-1:0]       q;     // life ratio
    logic [FRAC_BITS-1:0]       r2;
    logic [OPA_W-1:0]           opa;
  } stage_t;

  logic signed [CFG_W-1:0]  gravity_accel;
  logic [DRAG_W-1:0]        drag_coeff;
  stage_t                   st0;
  stage_t                   pipe [NST];
  stage_t                   nxt  [NST];
  logic [NST-1:0]           vld;
  logic [NST-1:0]           en;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_accel <= '0;
      drag_coeff    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAVITY: gravity_accel <= cfg_data;
        REG_DRAG:    drag_coeff    <= cfg_data[DRAG_W-1:0];
        default:     ;
      endcase
    end
  end

  // stall chain: a stage moves when empty or when its successor moves
  always_comb begin
    en[NST-1] = !vld[NST-1] || m_axis_tready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end
  assign s_axis_tready = en[0];

  // stage 0: age, expiry, gravity and drag products
  always_comb begin
    logic [AGE_W:0]   sum;
    logic [AGE_W-1:0] na;
    logic             act;
    st0         = '0;
    act         = s_axis_tdata[0];
    st0.max_age = s_axis_tdata[48:25];
    st0.pos[0]  = s_axis_tdata[80:49];
    st0.pos[1]  = s_axis_tdata[112:81];
    st0.pos[2]  = s_axis_tdata[144:113];
    st0.vel[0]  = s_axis_tdata[176:145];
    st0.vel[1]  = s_axis_tdata[208:177];
    st0.vel[2]  = s_axis_tdata[240:209];
    st0.base    = s_axis_tdata[257:241];
    st0.dt      = s_axis_tdata[273:258];
    sum = {1'b0, s_axis_tdata[24:1]} + (AGE_W+1)'(st0.dt);
    na  = sum[AGE_W] ? '1 : sum[AGE_W-1:0];
    st0.age   = act ? na : s_axis_tdata[24:1];
    st0.alive = act && (na < st0.max_age);
    st0.rem   = na;
    st0.gp    = gravity_accel * $signed({1'b0, st0.dt});
    st0.dp    = drag_coeff * st0.dt;
  end

  // later stages
  always_comb begin
    logic [AGE_W:0]                 t;
    logic signed [63:0]             w;
    logic signed [POS_W+DT_W+1:0]   kk;
    logic signed [POS_W+FRAC_BITS+1:0] vk;
    logic [2*FRAC_BITS-1:0]         sq;
    logic [OPA_W+FRAC_BITS:0]       op;
    t  = '0;
    w  = '0;
    kk = '0;
    vk = '0;
    sq = '0;
    op = '0;
    nxt[0] = st0;
    for (int s = 1; s < NST; s++) begin
      nxt[s] = pipe[s-1];
      // restoring divide, one quotient bit per stage, MSB first
      if (s <= FRAC_BITS) begin
        t = {pipe[s-1].rem, 1'b0};
        if (t >= {1'b0, pipe[s-1].max_age}) begin
          t = t - {1'b0, pipe[s-1].max_age};
          nxt[s].q[FRAC_BITS-s] = 1'b1;
        end
        nxt[s].rem = t[AGE_W-1:0];
      end
      if (s == 1) begin
        w  = 64'($signed(pipe[0].vel[1])) - 64'(pipe[0].gp >>> FRAC_BITS);
        kk = (POS_W+DT_W+2)'(1 << FRAC_BITS) - (POS_W+DT_W+2)'(pipe[0].dp >> FRAC_BITS);
        nxt[s].k = kk < 0 ? '0 : kk[FRAC_BITS:0];
        if (pipe[0].alive) nxt[s].vel[1] = sat32(w);
      end
      if (s == 2 && pipe[1].alive) begin
        for (int i = 0; i < 3; i++) begin
          vk = $signed(pipe[1].vel[i]) * $signed({1'b0, pipe[1].k});
          w  = 64'(vk >>> FRAC_BITS);
          nxt[s].vel[i] = sat32(w);
        end
      end
      if (s == 3) begin
        for (int i = 0; i < 3; i++) begin
          nxt[s].pm[i] = $signed(pipe[2].vel[i]) * $signed({1'b0, pipe[2].dt});
        end
      end
      if (s == 4 && pipe[3].alive) begin
        for (int i = 0; i < 3; i++) begin
          w = 64'($signed(pipe[3].pos[i])) + 64'($signed(pipe[3].pm[i]) >>> FRAC_BITS);
          nxt[s].pos[i] = sat32(w);
        end
      end
      if (s == FRAC_BITS + 1) begin
        sq = pipe[s-1].q * pipe[s-1].q;
        nxt[s].r2 = sq[2*FRAC_BITS-1:FRAC_BITS];
      end
      if (s == FRAC_BITS + 2) begin
        op = pipe[s-1].base *
             ((FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, pipe[s-1].r2});
        nxt[s].opa = pipe[s-1].alive ? op[FRAC_BITS+OPA_W-1:FRAC_BITS] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NST; s++) begin
      if (en[s]) pipe[s] <= nxt[s];
    end
  end

  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tdata  = {6'd0, pipe[NST-1].opa,
                          pipe[NST-1].vel[2], pipe[NST-1].vel[1], pipe[NST-1].vel[0],
                          pipe[NST-1].pos[2], pipe[NST-1].pos[1], pipe[NST-1].pos[0],
                          pipe[NST-1].age, pipe[NST-1].alive};

  `PUS_ASSERT_NOW(a_dead_no_opacity, m_axis_tvalid && !m_axis_tdata[0],
    m_axis_tdata[233:217] == '0, "dead particle with nonzero opacity")
  `PUS_ASSERT_NOW(a_stall_only_full, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready, "input held off without output stall")
  `PUS_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready,
    vld[0], "accepted request not in first stage")
endmodule

[verif/particle_update_step_test.sv]
// particle_update_step_test: self-checking stream test of the particle update block.
// Depends on pus_pkg and particle_update_step; predicts each record in fixed point.
`timescale 1ns / 1ps
module particle_update_step_test
  import pus_pkg::*;
;

  localparam int LATENCY = FRAC_BITS_DEF + 3;

  typedef struct packed {
    logic [15:0] dt;
    logic [16:0] base;
    logic [31:0] vz, vy, vx, pz, py, px;
    logic [23:0] max_age, age;
    logic        active;
  } particle_t;

  localparam int PW = $bits(particle_t);

  typedef struct packed {
    logic [16:0] opacity;
    logic [31:0] vz, vy, vx, pz, py, px;
    logic [23:0] age;
    logic        active;
  } update_t;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we = 0, cfg_index = REG_GRAVITY;
  logic [CFG_W-1:0] cfg_data = '0;

  logic signed [31:0] gravity = 0;
  logic [15:0] drag = 0;
  update_t pending[$];
  int errors = 0;
  bit out_stall_on = 1;

  always #10 clk = ~clk;

  particle_update_step DUT (.*);

  function automatic longint fshift(longint x);
    return x >>> FRAC_BITS_DEF;  // arithmetic shift floors
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic update_t predict_update(particle_t p);
    update_t u;
    longint vel[3], pos[3], dt, k, r, r2, nage;
    vel[0] = $signed(p.vx); vel[1] = $signed(p.vy); vel[2] = $signed(p.vz);
    pos[0] = $signed(p.px); pos[1] = $signed(p.py); pos[2] = $signed(p.pz);
    dt = p.dt;
    u.active = p.active;
    u.age = p.age;
    u.opacity = '0;
    if (p.active) begin
      nage = p.age + dt;
      if (nage > 24'hFFFFFF) nage = 24'hFFFFFF;
      u.age = nage[23:0];
      if (nage >= p.max_age) begin
        u.active = 0;
      end else begin
        vel[1] = clamp32(vel[1] - fshift(longint'(gravity) * dt));
        k = (64'sd1 << FRAC_BITS_DEF) - ((longint'(drag) * dt) >>> FRAC_BITS_DEF);
        if (k < 0) k = 0;
        for (int i = 0; i < 3; i++) begin
          vel[i] = clamp32(fshift(vel[i] * k));
          pos[i] = clamp32(pos[i] + fshift(vel[i] * dt));
        end
        r = (nage << FRAC_BITS_DEF) / longint'(p.max_age);
        r2 = (r * r) >>> FRAC_BITS_DEF;
        u.opacity = 17'((longint'(p.base) * ((64'sd1 << FRAC_BITS_DEF) - r2))
                        >>> FRAC_BITS_DEF);
      end
    end
    u.px = pos[0][31:0]; u.py = pos[1][31:0]; u.pz = pos[2][31:0];
    u.vx = vel[0][31:0]; u.vy = vel[1][31:0]; u.vz = vel[2][31:0];
    return u;
  endfunction

  // one request into s_axis, with a random gap first when gaps is set
  task automatic send_particle(particle_t p, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= IN_W'(p);
    pending.push_back(predict_update(p));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic idle_wait();
    s_axis_tvalid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == REG_GRAVITY) gravity = val; else drag = val[15:0];
  endtask

  function automatic particle_t rand_particle(bit live);
    particle_t p;
    p = PW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom});
    p.active = live ? 1 : $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0: p.base = 17'd65536;
      1: p.base = 17'($urandom_range(0, 65536));
      default: p.base = 17'($urandom);
    endcase
    if (live && $urandom_range(0, 3) != 0) begin
      p.age = 24'($urandom_range(0, 24'h7FFFFF));
      p.max_age = p.age + 24'($urandom_range(1, 24'h7FFFFF));
      if ($urandom_range(0, 3) == 0) begin
        p.vx = 32'($signed($urandom_range(0, 65535 * 64)) - 65535 * 32);
        p.vy = 32'($signed($urandom_range(0, 65535 * 64)) - 65535 * 32);
      end
    end
    return p;
  endfunction

  // result checker; output stalls drawn per result
  always @(posedge clk) begin
    update_t got, exp_u;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = update_t'(m_axis_tdata[$bits(update_t)-1:0]);
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
      end else begin
        exp_u = pending.pop_front();
        if (got.active !== exp_u.active) begin
          $error("out_active exp %0d got %0d", exp_u.active, got.active); errors++;
        end
        if (got.age !== exp_u.age) begin
          $error("out_age exp %h got %h", exp_u.age, got.age); errors++;
        end
        if (got.px !== exp_u.px) begin
          $error("out_pos_x exp %h got %h", exp_u.px, got.px); errors++;
        end
        if (got.py !== exp_u.py) begin
          $error("out_pos_y exp %h got %h", exp_u.py, got.py); errors++;
        end
        if (got.pz !== exp_u.pz) begin
          $error("out_pos_z exp %h got %h", exp_u.pz, got.pz); errors++;
        end
        if (got.vx !== exp_u.vx) begin
          $error("out_vel_x exp %h got %h", exp_u.vx, got.vx); errors++;
        end
        if (got.vy !== exp_u.vy) begin
          $error("out_vel_y exp %h got %h", exp_u.vy, got.vy); errors++;
        end
        if (got.vz !== exp_u.vz) begin
          $error("out_vel_z exp %h got %h", exp_u.vz, got.vz); errors++;
        end
        if (got.opacity !== exp_u.opacity) begin
          $error("out_opacity exp %h got %h", exp_u.opacity, got.opacity); errors++;
        end
      end
    end
  end

  // ready pattern: per result a random stall, or none in a stretch
  initial begin
    int stall;
    forever begin
      stall = out_stall_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic test_directed();
    particle_t p;
    p = '0;
    send_particle(p);                          // dead, all zero
    p = '1; p.active = 0; send_particle(p);    // dead, all ones passes
    p = '0; p.active = 1; send_particle(p);    // max_age zero -> expires
    p.max_age = 24'h10000; p.age = 24'hFFFF; p.dt = 16'd1;
    send_particle(p);                          // reaches limit exactly
    p.age = 24'hFFFFFF; p.max_age = 24'hFFFFFF; p.dt = 16'hFFFF;
    send_particle(p);                          // age saturates
    p.age = 0; p.max_age = 24'hFFFFFF; p.base = 17'd65536; p.dt = 16'hFFFF;
    p.px = 32'h7FFFFFFF; p.vx = 32'h7FFFFFFF;
    p.py = 32'h80000000; p.vy = 32'h80000000;
    p.pz = 32'h80000000; p.vz = 32'h7FFFFFFF;
    send_particle(p);                          // position saturation
    p.base = 17'h1FFFF; send_particle(p);      // base above one
    p.age = 24'h1; p.max_age = 24'h2; p.dt = 0; send_particle(p);
    repeat (8) send_particle(rand_particle(1));
    idle_wait();
  endtask

  task automatic test_config_extremes();
    logic [31:0] grav[4] = '{32'h7FFFFFFF, 32'h80000000, 32'h00098000, 32'hFFFF0000};
    logic [31:0] drg[3] = '{32'h0000FFFF, 32'h0, 32'h00001000};
    foreach (grav[i]) begin
      write_reg(REG_GRAVITY, grav[i]);
      write_reg(REG_DRAG, drg[i % 3]);
      repeat (6) send_particle(rand_particle(1));
      idle_wait();
    end
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_GRAVITY, $urandom);
      write_reg(REG_DRAG, $urandom_range(0, 65535));
      out_stall_on = (phase != 2);
      for (int n = 0; n < 250; n++)
        send_particle(rand_particle($urandom_range(0, 7) != 0), phase != 3);
      idle_wait();
    end
    out_stall_on = 1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_stream();
    if (errors == 0 && pending.size() == 0) begin
      $display("particle_update_step: match");
    end else begin
      $display("particle_update_step: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("particle_update_step: mismatch");
    $finish;
  end
endmodule
